/* rtl/core/assert_macros.svh */
// Assertion macros used by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, muted in reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, muted in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/irl_pkg.sv */
// Package for the indexed record list: transfer types, opcodes, status codes, defaults.
package irl_pkg;

   // Default sizes
   localparam int MAX_ENTRIES_DEF  = 64;
   localparam int KEY_BITS_DEF     = 64;
   localparam int PAYLOAD_BITS_DEF = 32;

   // Request opcodes
   localparam logic [3:0] OP_INS_FIRST = 4'd0;
   localparam logic [3:0] OP_INS_LAST  = 4'd1;
   localparam logic [3:0] OP_INS_AT    = 4'd2;
   localparam logic [3:0] OP_DEL_FIRST = 4'd3;
   localparam logic [3:0] OP_DEL_LAST  = 4'd4;
   localparam logic [3:0] OP_DEL_AT    = 4'd5;
   localparam logic [3:0] OP_READ      = 4'd6;
   localparam logic [3:0] OP_WRITE     = 4'd7;
   localparam logic [3:0] OP_SEARCH    = 4'd8;

   // Result status codes
   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;
   localparam logic [1:0] STAT_RANGE = 2'd3;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [5:0]  index;
      logic [63:0] user_key;
      logic [31:0] user_payload;
   } irl_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        found;
      logic [5:0]  found_index;
      logic [63:0] read_key;
      logic [31:0] read_payload;
      logic [6:0]  entry_count;
      logic        is_empty;
      logic        is_full;
   } irl_rsp_type;

endpackage

/* rtl/core/irl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module irl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/indexed_record_list.sv */
// Indexed record list: ordered record store with a sequencer over one record RAM.
//
//   channel   ports                      direction   transfer
//   request   start, busy, req_data      in          start high while busy low
//   result    rsp_strobe, rsp_data       out         one cycle, rsp_strobe high
//
// Every request gives one result. One record moves through the RAM per cycle. Insert and
// delete at p move the records from p to the end of the list; delete last and rejected
// requests move none. busy is high from the request's acceptance until its result.
// Record storage is not cleared at reset; only the state and the count are, so no clearing pass.
// The receiver cannot stall: each result shows for exactly one cycle.
`include "assert_macros.svh"

module indexed_record_list #(
   parameter int MAX_ENTRIES  = irl_pkg::MAX_ENTRIES_DEF,
   parameter int KEY_BITS     = irl_pkg::KEY_BITS_DEF,
   parameter int PAYLOAD_BITS = irl_pkg::PAYLOAD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  irl_pkg::irl_req_type req_data,
   output logic                 rsp_strobe,
   output irl_pkg::irl_rsp_type rsp_data
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int XW = (CW > 6) ? CW : 6;
   localparam int RW = KEY_BITS + PAYLOAD_BITS;

   // Sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SHUP  = 3'd1;
   localparam logic [2:0] S_SHDN  = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_RDADR = 3'd4;
   localparam logic [2:0] S_RDCAP = 3'd5;
   localparam logic [2:0] S_WRITE = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]              state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           pos_ff, pos_in;
   logic [CW-1:0]           ptr_ff, ptr_in;
   logic [AW-1:0]           wa_ff, wa_in;
   logic                    pend_ff, pend_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;
   logic [1:0]              status_ff, status_in;
   logic                    found_ff, found_in;
   logic [AW-1:0]           fidx_ff, fidx_in;
   logic [KEY_BITS-1:0]     rkey_ff, rkey_in;
   logic [PAYLOAD_BITS-1:0] rpay_ff, rpay_in;

   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [RW-1:0] mem_wdata, mem_rdata;

   logic          accept, is_full, is_empty, key_hit;
   logic [XW-1:0] idx_x, cnt_x;

   assign accept   = start && !busy;
   assign is_full  = count_ff == CW'(MAX_ENTRIES);
   assign is_empty = count_ff == '0;
   assign idx_x    = XW'(req_data.index);
   assign cnt_x    = XW'(count_ff);
   assign key_hit  = mem_rdata[RW-1:PAYLOAD_BITS] == key_ff;

   irl_ram #(
      .WIDTH (RW),
      .DEPTH (MAX_ENTRIES)
   ) u_records (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Sequencer: dispatch, shift, scan and respond
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      ptr_in    = ptr_ff;
      wa_in     = wa_ff;
      pend_in   = pend_ff;
      key_in    = key_ff;
      pay_in    = pay_ff;
      status_in = status_ff;
      found_in  = found_ff;
      fidx_in   = fidx_ff;
      rkey_in   = rkey_ff;
      rpay_in   = rpay_ff;
      mem_we    = 1'b0;
      mem_waddr = wa_ff;
      mem_wdata = mem_rdata;
      mem_re    = 1'b0;
      mem_raddr = AW'(ptr_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in    = req_data.user_key[KEY_BITS-1:0];
               pay_in    = PAYLOAD_BITS'(req_data.user_payload);
               status_in = irl_pkg::STAT_DONE;
               found_in  = 1'b0;
               fidx_in   = '0;
               rkey_in   = '0;
               rpay_in   = '0;
               pend_in   = 1'b0;
               state_in  = S_DONE;
               unique case (req_data.opcode)
                  irl_pkg::OP_INS_FIRST, irl_pkg::OP_INS_LAST, irl_pkg::OP_INS_AT: begin
                     if (is_full) begin
                        status_in = irl_pkg::STAT_FULL;
                     end else if (req_data.opcode == irl_pkg::OP_INS_AT && idx_x > cnt_x) begin
                        status_in = irl_pkg::STAT_RANGE;
                     end else begin
                        ptr_in   = count_ff;
                        state_in = S_SHUP;
                        if (req_data.opcode == irl_pkg::OP_INS_FIRST) begin
                           pos_in = '0;
                        end else if (req_data.opcode == irl_pkg::OP_INS_LAST) begin
                           pos_in = count_ff;
                        end else begin
                           pos_in = CW'(idx_x);
                        end
                     end
                  end
                  irl_pkg::OP_DEL_FIRST, irl_pkg::OP_DEL_LAST, irl_pkg::OP_DEL_AT: begin
                     if (is_empty) begin
                        status_in = irl_pkg::STAT_EMPTY;
                     end else if (req_data.opcode == irl_pkg::OP_DEL_LAST) begin
                        count_in = count_ff - 1'b1;
                     end else if (req_data.opcode == irl_pkg::OP_DEL_AT && idx_x >= cnt_x) begin
                        status_in = irl_pkg::STAT_RANGE;
                     end else begin
                        pos_in   = (req_data.opcode == irl_pkg::OP_DEL_AT) ? CW'(idx_x) : '0;
                        ptr_in   = (req_data.opcode == irl_pkg::OP_DEL_AT) ? CW'(idx_x) : '0;
                        state_in = S_SHDN;
                     end
                  end
                  irl_pkg::OP_READ, irl_pkg::OP_WRITE: begin
                     if (is_empty) begin
                        status_in = irl_pkg::STAT_EMPTY;
                     end else if (idx_x >= cnt_x) begin
                        status_in = irl_pkg::STAT_RANGE;
                     end else begin
                        pos_in   = CW'(idx_x);
                        state_in = (req_data.opcode == irl_pkg::OP_READ) ? S_RDADR : S_WRITE;
                     end
                  end
                  irl_pkg::OP_SEARCH: begin
                     ptr_in   = '0;
                     state_in = S_SCAN;
                  end
                  default: begin
                     status_in = irl_pkg::STAT_RANGE;
                  end
               endcase
            end
         end

         // Move records up one place, top first, then drop the new record in
         S_SHUP: begin
            mem_we = pend_ff;
            if (ptr_ff > pos_ff) begin
               mem_re    = 1'b1;
               mem_raddr = AW'(ptr_ff - 1'b1);
               wa_in     = AW'(ptr_ff);
               ptr_in    = ptr_ff - 1'b1;
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = AW'(pos_ff);
                  mem_wdata = {key_ff, pay_ff};
                  count_in  = count_ff + 1'b1;
                  state_in  = S_DONE;
               end
            end
         end

         // Move records down one place, bottom first
         S_SHDN: begin
            mem_we = pend_ff;
            if ((CW + 1)'(ptr_ff) + 1'b1 < (CW + 1)'(count_ff)) begin
               mem_re    = 1'b1;
               mem_raddr = AW'(ptr_ff + 1'b1);
               wa_in     = AW'(ptr_ff);
               ptr_in    = ptr_ff + 1'b1;
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in = count_ff - 1'b1;
                  state_in = S_DONE;
               end
            end
         end

         // Read one record a cycle and compare its key in the next cycle
         S_SCAN: begin
            if (pend_ff && key_hit) begin
               found_in = 1'b1;
               fidx_in  = wa_ff;
               pend_in  = 1'b0;
               state_in = S_DONE;
            end else if (ptr_ff < count_ff) begin
               mem_re    = 1'b1;
               mem_raddr = AW'(ptr_ff);
               wa_in     = AW'(ptr_ff);
               ptr_in    = ptr_ff + 1'b1;
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_DONE;
               end
            end
         end

         S_RDADR: begin
            mem_re    = 1'b1;
            mem_raddr = AW'(pos_ff);
            state_in  = S_RDCAP;
         end

         S_RDCAP: begin
            rkey_in  = mem_rdata[RW-1:PAYLOAD_BITS];
            rpay_in  = mem_rdata[PAYLOAD_BITS-1:0];
            state_in = S_DONE;
         end

         S_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(pos_ff);
            mem_wdata = {key_ff, pay_ff};
            state_in  = S_DONE;
         end

         S_DONE: begin
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      ptr_ff    <= ptr_in;
      wa_ff     <= wa_in;
      key_ff    <= key_in;
      pay_ff    <= pay_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      fidx_ff   <= fidx_in;
      rkey_ff   <= rkey_in;
      rpay_ff   <= rpay_in;
   end

   // Result transfer
   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = state_ff == S_DONE;

   always_comb begin
      rsp_data.status       = status_ff;
      rsp_data.found        = found_ff;
      rsp_data.found_index  = 6'(fidx_ff);
      rsp_data.read_key     = 64'(rkey_ff);
      rsp_data.read_payload = 32'(rpay_ff);
      rsp_data.entry_count  = 7'(count_ff);
      rsp_data.is_empty     = is_empty;
      rsp_data.is_full      = is_full;
   end

   // Checks
   `ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_ENTRIES), "count overflow")
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted request left idle")
   `ASSERT_NEXT(a_strobe_once, clock, reset, rsp_strobe, !rsp_strobe && !busy, "result repeated")
   `ASSERT_IMPL(a_write_in_list, clock, reset, mem_we, CW'(mem_waddr) <= count_ff, "write past list end")
   `ASSERT_IMPL(a_flags_excl, clock, reset, rsp_strobe, !(rsp_data.is_empty && rsp_data.is_full), "empty and full together")

endmodule

/* sim/tb_top.sv */
// Testbench for the indexed record list: directed rows then random list traffic against a shadow list.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import irl_pkg::*;

   localparam int CLOCK_HALF   = 4;
   localparam int LIST_DEPTH   = MAX_ENTRIES_DEF;
   localparam int RANDOM_ITEMS = 800;
   localparam int QUIET_LIMIT  = 2000;
   // longest operation is a search with no match on a full list
   localparam int DRAIN_CYCLES = 80;

   // opcodes the block does not know
   localparam logic [3:0] OP_BAD_LOW  = 4'd9;
   localparam logic [3:0] OP_BAD_MID  = 4'd12;
   localparam logic [3:0] OP_BAD_HIGH = 4'd15;

   typedef struct {
      irl_req_type rq;
      bit          typed;
      irl_rsp_type want;
   } stim_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   irl_req_type req_data = '0;
   logic        rsp_strobe;
   irl_rsp_type rsp_data;

   // shadow of the record list
   logic [63:0] list_keys [LIST_DEPTH];
   logic [31:0] list_payloads [LIST_DEPTH];
   int unsigned list_count = 0;

   irl_rsp_type list_outcomes_due [$];
   bit          due_typed = 1'b0;
   irl_rsp_type due_typed_rsp = '0;
   int unsigned sender_idle_pct = 18;
   int unsigned fail_count = 0;
   int unsigned quiet_cycles = 0;

   indexed_record_list DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // Apply one request to the shadow list and return the result it gives
   function automatic irl_rsp_type apply_list_op(irl_req_type rq);
      irl_rsp_type res;
      int          pos;
      int          i;
      res = '0;
      pos = -1;
      case (rq.opcode)
         OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
            if (list_count == LIST_DEPTH) begin
               res.status = STAT_FULL;
            end else if (rq.opcode == OP_INS_AT && rq.index > list_count) begin
               res.status = STAT_RANGE;
            end else begin
               pos = (rq.opcode == OP_INS_FIRST) ? 0 :
                     (rq.opcode == OP_INS_LAST) ? int'(list_count) : int'(rq.index);
               // shift later records up to open the slot
               for (i = list_count; i > pos; i--) begin
                  list_keys[i]     = list_keys[i - 1];
                  list_payloads[i] = list_payloads[i - 1];
               end
               list_keys[pos]     = rq.user_key;
               list_payloads[pos] = rq.user_payload;
               list_count++;
            end
         end
         OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
            if (list_count == 0) begin
               res.status = STAT_EMPTY;
            end else if (rq.opcode == OP_DEL_AT && rq.index >= list_count) begin
               res.status = STAT_RANGE;
            end else begin
               pos = (rq.opcode == OP_DEL_FIRST) ? 0 :
                     (rq.opcode == OP_DEL_LAST) ? int'(list_count) - 1 : int'(rq.index);
               // shift later records down to close the slot
               for (i = pos; i + 1 < list_count; i++) begin
                  list_keys[i]     = list_keys[i + 1];
                  list_payloads[i] = list_payloads[i + 1];
               end
               list_count--;
            end
         end
         OP_READ, OP_WRITE: begin
            if (list_count == 0) begin
               res.status = STAT_EMPTY;
            end else if (rq.index >= list_count) begin
               res.status = STAT_RANGE;
            end else if (rq.opcode == OP_READ) begin
               res.read_key     = list_keys[rq.index];
               res.read_payload = list_payloads[rq.index];
            end else begin
               list_keys[rq.index]     = rq.user_key;
               list_payloads[rq.index] = rq.user_payload;
            end
         end
         OP_SEARCH: begin
            // lowest matching position wins
            for (i = 0; i < list_count; i++) begin
               if (!res.found && list_keys[i] == rq.user_key) begin
                  res.found       = 1'b1;
                  res.found_index = 6'(i);
               end
            end
         end
         default: begin
            res.status = STAT_RANGE;
         end
      endcase
      res.entry_count = 7'(list_count);
      res.is_empty    = (list_count == 0);
      res.is_full     = (list_count == LIST_DEPTH);
      return res;
   endfunction

   function automatic irl_rsp_type plain_outcome(logic [1:0] st, int cnt, logic [63:0] rkey,
                                                 logic [31:0] rpay);
      irl_rsp_type res;
      res              = '0;
      res.status       = st;
      res.read_key     = rkey;
      res.read_payload = rpay;
      res.entry_count  = 7'(cnt);
      res.is_empty     = (cnt == 0);
      res.is_full      = (cnt == LIST_DEPTH);
      return res;
   endfunction

   function automatic stim_row_t make_row(logic [3:0] op, logic [5:0] idx, logic [63:0] key,
                                          logic [31:0] pay, bit typed, irl_rsp_type want);
      stim_row_t row;
      row.rq.opcode       = op;
      row.rq.index        = idx;
      row.rq.user_key     = key;
      row.rq.user_payload = pay;
      row.typed           = typed;
      row.want            = want;
      return row;
   endfunction

   // Draw a random request, leaning towards inserts while filling and deletes while draining
   function automatic irl_req_type draw_request(bit filling);
      irl_req_type rq;
      int unsigned roll;
      int unsigned ins_share;
      int unsigned del_share;
      rq.user_payload = $urandom();
      rq.user_key     = {$urandom(), $urandom()};
      if ($urandom_range(99) < 85) begin
         rq.index = 6'($urandom_range(0, list_count));
      end else begin
         rq.index = 6'($urandom_range(0, 63));
      end
      ins_share = filling ? 60 : 15;
      del_share = filling ? 15 : 60;
      roll = $urandom_range(99);
      if (roll < ins_share) begin
         case ($urandom_range(2))
            0: rq.opcode = OP_INS_FIRST;
            1: rq.opcode = OP_INS_LAST;
            default: rq.opcode = OP_INS_AT;
         endcase
      end else if (roll < ins_share + del_share) begin
         case ($urandom_range(2))
            0: rq.opcode = OP_DEL_FIRST;
            1: rq.opcode = OP_DEL_LAST;
            default: rq.opcode = OP_DEL_AT;
         endcase
      end else if (roll < ins_share + del_share + 10) begin
         rq.opcode = OP_READ;
      end else if (roll < ins_share + del_share + 18) begin
         rq.opcode = OP_WRITE;
      end else if (roll < ins_share + del_share + 23) begin
         rq.opcode = OP_SEARCH;
      end else begin
         rq.opcode = 4'($urandom_range(OP_BAD_LOW, OP_BAD_HIGH));
      end
      // reuse held keys so searches hit and duplicates appear
      if (list_count != 0 &&
          $urandom_range(99) < ((rq.opcode == OP_SEARCH) ? 70 : 20)) begin
         rq.user_key = list_keys[$urandom_range(0, list_count - 1)];
      end
      return rq;
   endfunction

   task automatic report_mismatch(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      fail_count++;
   endtask

   task automatic compare_outcome(irl_rsp_type got, irl_rsp_type want);
      if (got.status !== want.status)
         report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.found !== want.found)
         report_mismatch($sformatf("found %0b, expected %0b", got.found, want.found));
      if (got.found_index !== want.found_index)
         report_mismatch($sformatf("found_index %0d, expected %0d",
                                   got.found_index, want.found_index));
      if (got.read_key !== want.read_key)
         report_mismatch($sformatf("read_key %h, expected %h", got.read_key, want.read_key));
      if (got.read_payload !== want.read_payload)
         report_mismatch($sformatf("read_payload %h, expected %h",
                                   got.read_payload, want.read_payload));
      if (got.entry_count !== want.entry_count)
         report_mismatch($sformatf("entry_count %0d, expected %0d",
                                   got.entry_count, want.entry_count));
      if (got.is_empty !== want.is_empty)
         report_mismatch($sformatf("is_empty %0b, expected %0b", got.is_empty, want.is_empty));
      if (got.is_full !== want.is_full)
         report_mismatch($sformatf("is_full %0b, expected %0b", got.is_full, want.is_full));
   endtask

   // Present one request from a falling edge and hold it until the block takes it
   task automatic drive_item(irl_req_type rq, bit typed, irl_rsp_type want);
      while ($urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      req_data      = rq;
      due_typed     = typed;
      due_typed_rsp = want;
      start         = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Predict on each request transfer, check each result transfer
   always @(posedge clock) begin : monitor_transfers
      irl_rsp_type want;
      if (!reset) begin
         if (start && !busy) begin
            want = apply_list_op(req_data);
            if (due_typed)
               want = due_typed_rsp;
            list_outcomes_due.push_back(want);
         end
         if (rsp_strobe) begin
            if (list_outcomes_due.size() == 0)
               report_mismatch("result with no request outstanding");
            else
               compare_outcome(rsp_data, list_outcomes_due.pop_front());
         end
      end
   end

   // Stop a hung run: count cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      stim_row_t   rows [$];
      irl_rsp_type none;
      irl_req_type rq;
      bit          filling;
      int          n;

      none = '0;
      // hold reset, then release it on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty list: every removal, read and write is refused; search finds nothing, bad requests get a range status
      rows.push_back(make_row(OP_DEL_FIRST, 6'd0, '0, '0, 1, plain_outcome(STAT_EMPTY, 0, 0, 0)));
      rows.push_back(make_row(OP_DEL_LAST, 6'd0, '0, '0, 1, plain_outcome(STAT_EMPTY, 0, 0, 0)));
      rows.push_back(make_row(OP_DEL_AT, 6'd0, '0, '0, 1, plain_outcome(STAT_EMPTY, 0, 0, 0)));
      rows.push_back(make_row(OP_READ, 6'd0, '0, '0, 1, plain_outcome(STAT_EMPTY, 0, 0, 0)));
      rows.push_back(make_row(OP_WRITE, 6'd0, '1, '1, 1, plain_outcome(STAT_EMPTY, 0, 0, 0)));
      rows.push_back(make_row(OP_SEARCH, 6'd0, '0, '0, 1, plain_outcome(STAT_DONE, 0, 0, 0)));
      rows.push_back(make_row(OP_INS_AT, 6'd1, '0, '0, 1, plain_outcome(STAT_RANGE, 0, 0, 0)));
      rows.push_back(make_row(OP_BAD_LOW, 6'd0, '0, '0, 1, plain_outcome(STAT_RANGE, 0, 0, 0)));
      rows.push_back(make_row(OP_BAD_HIGH, 6'h3F, '1, '1, 1,
                              plain_outcome(STAT_RANGE, 0, 0, 0)));
      // build a short list with extreme keys and payloads and read it back
      rows.push_back(make_row(OP_INS_AT, 6'd0, '1, '1, 1, plain_outcome(STAT_DONE, 1, 0, 0)));
      rows.push_back(make_row(OP_INS_FIRST, 6'd0, '0, '0, 1,
                              plain_outcome(STAT_DONE, 2, 0, 0)));
      rows.push_back(make_row(OP_INS_LAST, 6'd0, 64'h8000_0000_0000_0000, 32'h8000_0000, 1,
                              plain_outcome(STAT_DONE, 3, 0, 0)));
      rows.push_back(make_row(OP_READ, 6'd0, '0, '0, 1, plain_outcome(STAT_DONE, 3, 0, 0)));
      rows.push_back(make_row(OP_READ, 6'd1, '0, '0, 1, plain_outcome(STAT_DONE, 3, '1, '1)));
      // insert at an index equal to the count appends
      rows.push_back(make_row(OP_INS_AT, 6'd3, 64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF, 0,
                              none));
      rows.push_back(make_row(OP_READ, 6'd4, '0, '0, 1, plain_outcome(STAT_RANGE, 4, 0, 0)));
      // duplicate key so the search must give the lowest index
      rows.push_back(make_row(OP_WRITE, 6'd2, '1, 32'h5A5A_5A5A, 0, none));
      rows.push_back(make_row(OP_SEARCH, 6'd0, '1, '0, 0, none));
      rows.push_back(make_row(OP_SEARCH, 6'd0, 64'h1, '0, 0, none));
      rows.push_back(make_row(OP_DEL_AT, 6'd4, '0, '0, 1, plain_outcome(STAT_RANGE, 4, 0, 0)));
      rows.push_back(make_row(OP_DEL_AT, 6'd1, '0, '0, 0, none));
      rows.push_back(make_row(OP_DEL_LAST, 6'd0, '0, '0, 0, none));
      rows.push_back(make_row(OP_WRITE, 6'h3F, '1, '1, 1, plain_outcome(STAT_RANGE, 2, 0, 0)));
      rows.push_back(make_row(OP_BAD_MID, 6'd0, '0, '0, 1, plain_outcome(STAT_RANGE, 2, 0, 0)));
      rows.push_back(make_row(OP_INS_AT, 6'h3F, '1, '1, 1, plain_outcome(STAT_RANGE, 2, 0, 0)));

      foreach (rows[r])
         drive_item(rows[r].rq, rows[r].typed, rows[r].want);

      // random traffic: swing the list between empty and full, idle rate in three phases
      filling = 1'b1;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n < RANDOM_ITEMS / 3)
            sender_idle_pct = 18;
         else if (n < 2 * RANDOM_ITEMS / 3)
            sender_idle_pct = 48;
         else
            sender_idle_pct = 0;
         // linger a few requests at each extreme before turning round
         if (filling && list_count == LIST_DEPTH && $urandom_range(99) < 30)
            filling = 1'b0;
         else if (!filling && list_count == 0 && $urandom_range(99) < 30)
            filling = 1'b1;
         rq = draw_request(filling);
         drive_item(rq, 1'b0, none);
      end
      start = 1'b0;

      // wait out the results still due, then watch for strays
      while (list_outcomes_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
